### rtl/core/zbs_pkg.sv
// ----------------------------------------------------------------------------
// zbs_pkg
// Shared types, widths and constants of the zoomed bitmap scaler.
// ----------------------------------------------------------------------------
package zbs_pkg;

    // field widths
    localparam int ZR_W      = 24;  // Q8.16 ratio
    localparam int PIX_W     = 12;  // pixel coordinate
    localparam int SCR_W     = 13;  // screen size
    localparam int FLD_W     = 9;   // field size
    localparam int COLOR_W   = 32;
    localparam int PROD_W    = ZR_W + PIX_W;
    localparam int CX_W      = PROD_W + 1 - 16;
    localparam int WORD_BITS = 32;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int CFG_IDX_W = 3;

    // default parameter values
    localparam int FIELD_COLS_DEF    = 256;
    localparam int FIELD_ROWS_DEF    = 256;
    localparam int BORDER_PIXELS_DEF = 6;
    localparam int GRID_MIN_CELL_DEF = 18;

    // register reset values
    localparam logic [ZR_W-1:0]  RATIO_RST = 24'd65536;
    localparam logic [SCR_W-1:0] SCR_RST   = 13'd256;
    localparam logic [FLD_W-1:0] FLD_RST   = 9'd256;

    // round(1/ratio) >= g  <=>  ratio * (2g - 1) <= 2^17
    localparam logic [ZR_W:0] HALF_ROUND = 25'h8000;
    localparam int ONE_OVER_NUM = 131072;

    localparam logic [COLOR_W-1:0] COLOR_DEAD    = 32'h0000_0000;
    localparam logic [COLOR_W-1:0] COLOR_LIVE    = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] COLOR_OVERLAY = 32'h2288_8888;

    localparam logic CMD_SET    = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZOOM_X   = 3'd0,
        REG_ZOOM_Y   = 3'd1,
        REG_FIT_X    = 3'd2,
        REG_FIT_Y    = 3'd3,
        REG_SCREEN_W = 3'd4,
        REG_SCREEN_H = 3'd5,
        REG_FIELD_W  = 3'd6,
        REG_FIELD_H  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [ZR_W-1:0]  zoom_x;
        logic [ZR_W-1:0]  zoom_y;
        logic [ZR_W-1:0]  fit_x;
        logic [ZR_W-1:0]  fit_y;
        logic [SCR_W-1:0] scr_w;
        logic [SCR_W-1:0] scr_h;
        logic [FLD_W-1:0] fld_w;
        logic [FLD_W-1:0] fld_h;
    } cfg_t;

    // decisions handed from the mapper to the sequencer
    typedef struct packed {
        logic cmd;
        logic val;
        logic in_field;
        logic overlay;
    } map_flags_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

### rtl/core/zbs_ram.sv
// ----------------------------------------------------------------------------
// zbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module zbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/zbs_map.sv
// ----------------------------------------------------------------------------
// zbs_map
// Two-stage pixel to cell mapping: ratio products, then cell index,
// field check, border and grid overlay, and the word address of the cell.
// ----------------------------------------------------------------------------
module zbs_map import zbs_pkg::*; #(
    parameter int FIELD_COLS    = FIELD_COLS_DEF,
    parameter int FIELD_ROWS    = FIELD_ROWS_DEF,
    parameter int BORDER_PIXELS = BORDER_PIXELS_DEF,
    parameter int GRID_MIN_CELL = GRID_MIN_CELL_DEF,
    parameter int ADDR_W        = 11
) (
    input  logic              clk,
    input  logic              load,
    input  logic              command,
    input  logic [PIX_W-1:0]  pixel_x,
    input  logic [PIX_W-1:0]  pixel_y,
    input  logic              cell_value,
    input  cfg_t              cfg,
    output map_flags_t        flags,
    output logic [ADDR_W-1:0] word_addr,
    output logic [OFF_W-1:0]  word_off
);

    localparam int CXI_W     = $clog2(FIELD_COLS);
    localparam int CYI_W     = $clog2(FIELD_ROWS);
    localparam int BIT_W     = $clog2(FIELD_COLS * FIELD_ROWS);
    localparam int BORD_W    = SCR_W + 1;
    localparam int LARGE_MAX = ONE_OVER_NUM / (2 * GRID_MIN_CELL - 1);

    function automatic logic [CX_W-1:0] round_cell(input logic [PROD_W-1:0] prod);
        logic [PROD_W:0] sum;
        begin
            sum = {1'b0, prod} + (PROD_W + 1)'(HALF_ROUND);
            round_cell = sum[PROD_W:16];
        end
    endfunction

    function automatic logic in_border(input logic [PIX_W-1:0] p,
                                       input logic [SCR_W-1:0] size);
        logic [BORD_W-1:0] pw;
        begin
            pw = BORD_W'(p);
            in_border = (pw < BORD_W'(BORDER_PIXELS)) ||
                        ((pw + BORD_W'(BORDER_PIXELS)) >= BORD_W'(size));
        end
    endfunction

    // stage 1
    logic [PROD_W-1:0] prod_x_reg, prod_xp_reg, prod_y_reg, prod_yp_reg;
    logic              px_nz_reg, py_nz_reg, border_reg, grid_on_reg;
    logic              cmd_reg, val_reg;

    logic zoomed;
    logic large_x, large_y;

    assign zoomed  = (cfg.zoom_x != cfg.fit_x) || (cfg.zoom_y != cfg.fit_y);
    assign large_x = cfg.zoom_x <= ZR_W'(LARGE_MAX);
    assign large_y = cfg.zoom_y <= ZR_W'(LARGE_MAX);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_x_reg  <= PROD_W'(cfg.zoom_x) * PROD_W'(pixel_x);
            prod_xp_reg <= PROD_W'(cfg.zoom_x) * PROD_W'(pixel_x - PIX_W'(1));
            prod_y_reg  <= PROD_W'(cfg.zoom_y) * PROD_W'(pixel_y);
            prod_yp_reg <= PROD_W'(cfg.zoom_y) * PROD_W'(pixel_y - PIX_W'(1));
            px_nz_reg   <= pixel_x != '0;
            py_nz_reg   <= pixel_y != '0;
            border_reg  <= zoomed && (in_border(pixel_x, cfg.scr_w) ||
                                      in_border(pixel_y, cfg.scr_h));
            grid_on_reg <= zoomed && large_x && large_y;
            cmd_reg     <= command;
            val_reg     <= cell_value;
        end
    end

    // stage 2
    logic [CX_W-1:0]  cx, cxp, cy, cyp;
    logic             grid_edge, in_field;
    logic [BIT_W-1:0] bit_idx;

    always_comb
    begin
        cx  = round_cell(prod_x_reg);
        cxp = round_cell(prod_xp_reg);
        cy  = round_cell(prod_y_reg);
        cyp = round_cell(prod_yp_reg);
        grid_edge = (px_nz_reg && (cx != cxp)) || (py_nz_reg && (cy != cyp));
        in_field = (cx < CX_W'(cfg.fld_w)) && (cx < CX_W'(FIELD_COLS)) &&
                   (cy < CX_W'(cfg.fld_h)) && (cy < CX_W'(FIELD_ROWS));
        bit_idx = BIT_W'(cy[CYI_W-1:0]) * BIT_W'(FIELD_COLS) + BIT_W'(cx[CXI_W-1:0]);
    end

    map_flags_t       flags_reg;
    logic [ADDR_W-1:0] word_reg;
    logic [OFF_W-1:0]  off_reg;

    always_ff @(posedge clk)
    begin
        flags_reg.cmd      <= cmd_reg;
        flags_reg.val      <= val_reg;
        flags_reg.in_field <= in_field;
        flags_reg.overlay  <= border_reg || (grid_on_reg && grid_edge);
        word_reg           <= ADDR_W'(bit_idx >> OFF_W);
        off_reg            <= bit_idx[OFF_W-1:0];
    end

    assign flags     = flags_reg;
    assign word_addr = word_reg;
    assign word_off  = off_reg;

endmodule

### rtl/core/zoomed_bitmap_scaler_with_grid_unit.sv
// ----------------------------------------------------------------------------
// zoomed_bitmap_scaler_with_grid_unit
// One-bit cell bitmap with zoomed pixel to cell mapping, border and grid
// overlay. Cells are packed 32 to a ram word and updated read-modify-write.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    command, pixel_x, pixel_y,
//                                              cell_value
//   out      from block out_valid / out_stall  pixel_color
//   cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item passes from accept to the next accept through multiply, map to
// a word address, ram read, then write back or load the result register
// the ram read-modify-write of one item finishes before the next read, so
// no forwarding is needed
// after reset the store is swept clear, one word a cycle, over all
// ceil(FIELD_COLS*FIELD_ROWS/32) words (2048 by default), input stalled
// while a result waits on out_stall the next render holds in its last cycle
// config writes are taken in every cycle, also during the clear sweep
// ----------------------------------------------------------------------------
module zoomed_bitmap_scaler_with_grid_unit import zbs_pkg::*; #(
    parameter int FIELD_COLS    = FIELD_COLS_DEF,
    parameter int FIELD_ROWS    = FIELD_ROWS_DEF,
    parameter int BORDER_PIXELS = BORDER_PIXELS_DEF,
    parameter int GRID_MIN_CELL = GRID_MIN_CELL_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [PIX_W-1:0]     pixel_x,
    input  logic [PIX_W-1:0]     pixel_y,
    input  logic                 cell_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COLOR_W-1:0]   pixel_color,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ZR_W-1:0]      cfg_data
);

    localparam int WORDS  = (FIELD_COLS * FIELD_ROWS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = $clog2(WORDS);

    // configuration registers
    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ZOOM_X:   cfg_next.zoom_x = cfg_data;
                REG_ZOOM_Y:   cfg_next.zoom_y = cfg_data;
                REG_FIT_X:    cfg_next.fit_x  = cfg_data;
                REG_FIT_Y:    cfg_next.fit_y  = cfg_data;
                REG_SCREEN_W: cfg_next.scr_w  = cfg_data[SCR_W-1:0];
                REG_SCREEN_H: cfg_next.scr_h  = cfg_data[SCR_W-1:0];
                REG_FIELD_W:  cfg_next.fld_w  = cfg_data[FLD_W-1:0];
                REG_FIELD_H:  cfg_next.fld_h  = cfg_data[FLD_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zoom_x <= RATIO_RST;
            cfg_reg.zoom_y <= RATIO_RST;
            cfg_reg.fit_x  <= RATIO_RST;
            cfg_reg.fit_y  <= RATIO_RST;
            cfg_reg.scr_w  <= SCR_RST;
            cfg_reg.scr_h  <= SCR_RST;
            cfg_reg.fld_w  <= FLD_RST;
            cfg_reg.fld_h  <= FLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // mapping pipeline
    logic              in_accept;
    map_flags_t        flags;
    logic [ADDR_W-1:0] word_addr;
    logic [OFF_W-1:0]  word_off;

    zbs_map #(
        .FIELD_COLS    (FIELD_COLS),
        .FIELD_ROWS    (FIELD_ROWS),
        .BORDER_PIXELS (BORDER_PIXELS),
        .GRID_MIN_CELL (GRID_MIN_CELL),
        .ADDR_W        (ADDR_W)
    ) u_map (
        .clk        (clk),
        .load       (in_accept),
        .command    (command),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .cell_value (cell_value),
        .cfg        (cfg_reg),
        .flags      (flags),
        .word_addr  (word_addr),
        .word_off   (word_off)
    );

    // cell store
    logic                 ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data, merged;

    zbs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (word_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        merged           = ram_rd_data;
        merged[word_off] = flags.val;
    end

    // sequencer
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic                slot_free;

    assign in_stall  = state_reg != ST_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        color_next     = color_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = word_addr;
        ram_wr_data    = merged;
        ram_rd_en      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (flags.cmd == CMD_SET)
                begin
                    ram_wr_en  = flags.in_field;
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (flags.overlay)
                    begin
                        color_next = COLOR_OVERLAY;
                    end
                    else if (flags.in_field && ram_rd_data[word_off])
                    begin
                        color_next = COLOR_LIVE;
                    end
                    else
                    begin
                        color_next = COLOR_DEAD;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = color_reg;

endmodule

### rtl/core/zbs_checker.sv
// ----------------------------------------------------------------------------
// zbs_checker
// Port-level checks of the bitmap scaler, bound to the top level.
// ----------------------------------------------------------------------------
module zbs_checker import zbs_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               command,
    input logic               out_valid,
    input logic               out_stall,
    input logic [COLOR_W-1:0] pixel_color
);

    // a new result must trace back to an accepted render item
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && command == CMD_RENDER, 4))
        else $error("result without a render item four cycles before");

    // one item at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("item accepted while another is in flight");

    // input held off while the store is swept after reset
    a_clear_stall: assert property (@(posedge clk)
        $rose(rst_n) |-> in_stall)
        else $error("item taken during store clear");

    a_color_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_color == COLOR_DEAD || pixel_color == COLOR_LIVE ||
                       pixel_color == COLOR_OVERLAY))
        else $error("unknown pixel color");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pixel_color)))
        else $error("stalled result changed");

endmodule

bind zoomed_bitmap_scaler_with_grid_unit zbs_checker u_zbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_color (pixel_color)
);
